// ===== src/etr_pkg.sv =====
// Package for the elapsed-time reconciler: types, constants, register codes.
`default_nettype none
package etr_pkg;

  localparam int unsigned TagBytesDefault = 16;
  localparam int unsigned DivSteps = 33;

  localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Int64Min = 64'h8000_0000_0000_0000;

  // configuration register indexes
  localparam logic [2:0] RegCreditMax = 3'd0;
  localparam logic [2:0] RegCareTick  = 3'd1;
  localparam logic [2:0] RegNtpSlack  = 3'd2;
  localparam logic [2:0] RegTzShift   = 3'd3;
  localparam logic [2:0] RegTzLowest  = 3'd4;
  localparam logic [2:0] RegTzHighest = 3'd5;

  typedef enum logic [2:0] {
    StIdle,
    StCompare,
    StCredit,
    StDivide,
    StFinish,
    StOutput
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic compare;
    logic credit;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } status_t;

  // saturating signed 64-bit subtraction
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    begin
      d = {a[63], a} - {b[63], b};
      if (d[64] != d[63]) sat_sub = d[64] ? Int64Min : Int64Max;
      else sat_sub = d[63:0];
    end
  endfunction

  // magnitude with the most negative value clamped
  function automatic logic [63:0] magnitude(input logic [63:0] v);
    begin
      if (!v[63]) magnitude = v;
      else if (v == Int64Min) magnitude = Int64Max;
      else magnitude = -v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/etr_ctrl.sv =====
// Controller state machine for the elapsed-time reconciler.
`default_nettype none
module etr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  input  wire logic            out_free_i,
  input  wire etr_pkg::status_t status_i,
  output etr_pkg::cmd_t        cmd_o,
  output logic                 busy_o,
  output logic                 out_load_o
);
  import etr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_load_o = 1'b0;
    busy_o = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d = StCompare;
        end
      end
      StCompare: begin
        cmd_o.compare = 1'b1;
        state_d = StCredit;
      end
      StCredit: begin
        cmd_o.credit = 1'b1;
        state_d = StDivide;
      end
      StDivide: begin
        if (status_i.div_done) state_d = StFinish;
        else cmd_o.div_step = 1'b1;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d = StOutput;
      end
      StOutput: begin
        // hand the result over once the output register is free
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    cmd_o.div_start = cmd_o.credit;
  end

endmodule
`default_nettype wire

// ===== src/etr_dp.sv =====
// Datapath: anchor registers, gap arithmetic and the iterative tick divider.
`default_nettype none
module etr_dp #(
  parameter int unsigned TagBytes = etr_pkg::TagBytesDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire etr_pkg::cmd_t     cmd_i,
  output etr_pkg::status_t       status_o,
  input  wire logic [287:0]      in_data_i,
  input  wire logic [31:0]       credit_max_i,
  input  wire logic [16:0]       care_tick_i,
  input  wire logic [31:0]       ntp_slack_i,
  input  wire logic [11:0]       tz_shift_i,
  input  wire logic [11:0]       tz_lowest_i,
  input  wire logic [10:0]       tz_highest_i,
  output logic [303:0]           result_o
);
  import etr_pkg::*;

  localparam int unsigned LoBytes = (TagBytes >= 8) ? 8 : TagBytes;
  localparam int unsigned HiBytes = (TagBytes > 8) ? TagBytes - 8 : 0;
  localparam logic [63:0] MaskLo = (LoBytes == 8) ? '1 : ((64'd1 << (8 * LoBytes)) - 64'd1);
  localparam logic [63:0] MaskHi = (HiBytes == 8) ? '1 :
                                   ((64'd1 << (8 * HiBytes)) - 64'd1);

  // observation registers
  logic [63:0] wall_q, boot_q, tlo_q, thi_q;
  logic [11:0] zone_q;
  // anchor
  logic [63:0] a_wall_q, a_boot_q, a_tlo_q, a_thi_q;
  logic [11:0] a_zone_q;
  logic        anchored_q;
  logic [16:0] rem_q;
  logic [63:0] total_q;
  // per-item results
  logic [62:0] trusted_q;
  logic [31:0] credited_q;
  logic [12:0] zdelta_q;
  logic        first_q, back_q, jump_q, shift_q, gave_q, same_q;
  logic [63:0] next_wall_q;
  // divider
  logic [32:0] quo_q;
  logic [16:0] drem_q;
  logic [16:0] tick_q;
  logic [5:0]  cnt_q;

  // zone cleaning on capture
  logic signed [31:0] zraw;
  logic        zok;
  assign zraw = in_data_i[287:256];
  assign zok  = (zraw >= $signed({{20{tz_lowest_i[11]}}, tz_lowest_i})) &&
                (zraw <= $signed({21'd0, tz_highest_i}));

  // compare-stage logic
  logic [63:0] wgap, bgap, tsel, dv;
  logic [12:0] zd, zmag;
  logic        same, shifted, jmp;
  always_comb begin
    wgap = sat_sub(wall_q, a_wall_q);
    bgap = sat_sub(boot_q, a_boot_q);
    zd = {zone_q[11], zone_q} - {a_zone_q[11], a_zone_q};
    zmag = zd[12] ? -zd : zd;
    shifted = zmag >= {1'b0, tz_shift_i};
    same = (((tlo_q ^ a_tlo_q) & MaskLo) == '0) && (((thi_q ^ a_thi_q) & MaskHi) == '0);
    dv = magnitude(sat_sub(wgap, bgap));
    jmp = 1'b0;
    if (same && !bgap[63]) begin
      if (wgap[63]) tsel = bgap;
      else begin
        tsel = ($signed(wgap) < $signed(bgap)) ? wgap : bgap;
        jmp = !shifted && (dv > {32'd0, ntp_slack_i});
      end
    end else tsel = wgap;
    if (tsel[63]) tsel = '0;
  end

  // credit capped at the configured maximum
  logic [31:0] credited_w;
  assign credited_w = (trusted_q > {31'd0, credit_max_i}) ? credit_max_i : trusted_q[31:0];

  // divider step: restoring, one quotient bit per cycle over the 33-bit pending
  logic [17:0] trial;
  assign trial = {drem_q, quo_q[32]} - {1'b0, tick_q};
  assign status_o.div_done = (cnt_q == 6'(DivSteps));

  logic [63:0] nsum;
  logic [16:0] remaining;
  assign remaining = tick_q - drem_q;
  assign nsum = wall_q + {47'd0, remaining};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_wall_q <= '0; a_boot_q <= '0; a_tlo_q <= '0; a_thi_q <= '0;
      a_zone_q <= '0; anchored_q <= 1'b0; rem_q <= '0; total_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.credit) begin
        cnt_q <= '0;
        total_q <= total_q + {32'd0, anchored_q ? credited_w : 32'd0};
      end else if (cmd_i.div_step) cnt_q <= cnt_q + 6'd1;
      if (cmd_i.finish) begin
        a_wall_q <= wall_q; a_boot_q <= boot_q; a_tlo_q <= tlo_q;
        a_thi_q <= thi_q; a_zone_q <= zone_q; anchored_q <= 1'b1;
        rem_q <= drem_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wall_q <= in_data_i[63:0];
      boot_q <= in_data_i[127:64];
      tlo_q  <= in_data_i[191:128];
      thi_q  <= in_data_i[255:192];
      zone_q <= zok ? zraw[11:0] : 12'd0;
      tick_q <= (care_tick_i == '0) ? 17'd1 : care_tick_i;
    end
    if (cmd_i.compare) begin
      first_q   <= !anchored_q;
      trusted_q <= anchored_q ? tsel[62:0] : '0;
      zdelta_q  <= anchored_q ? zd : '0;
      back_q    <= anchored_q && wgap[63];
      jump_q    <= anchored_q && jmp;
      shift_q   <= anchored_q && shifted;
      same_q    <= anchored_q && same;
    end
    if (cmd_i.div_start) begin
      credited_q <= anchored_q ? credited_w : 32'd0;
      gave_q     <= anchored_q && (trusted_q > {31'd0, credit_max_i});
      quo_q      <= {16'd0, rem_q} + {1'b0, anchored_q ? credited_w : 32'd0};
      drem_q     <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[17]) begin
        drem_q <= trial[16:0];
        quo_q  <= {quo_q[31:0], 1'b1};
      end else begin
        drem_q <= {drem_q[15:0], quo_q[32]};
        quo_q  <= {quo_q[31:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      next_wall_q <= (!wall_q[63] && nsum[63]) ? Int64Max : nsum;
    end
  end

  // result packing, first field lowest
  assign result_o = {
    93'd0,
    same_q, back_q | jump_q, gave_q, shift_q, jump_q, back_q, first_q,
    zdelta_q, next_wall_q, (quo_q[32] ? 32'hFFFF_FFFF : quo_q[31:0]),
    credited_q, trusted_q };

endmodule
`default_nettype wire

// ===== src/elapsed_time_reconciler_unit.sv =====
// Elapsed-time reconciler: one observation in, one reconciliation result out.
// Each observation passes the compare, credit, divide and finish states; the 33-step divider dominates.
// A new observation is taken only after the last result is handed to the output register.
// The input is taken only in idle; a finished result waits in the output register.
// Reset clears anchor, remainder, total and restores default register values.
`default_nettype none
module elapsed_time_reconciler_unit #(
  parameter int unsigned TagBytes = etr_pkg::TagBytesDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // wall_seconds, boot_seconds, boot_tag_low, boot_tag_high, zone_minutes
  input  wire logic [287:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // trusted_seconds, credited_seconds, ticks_earned, next_tick_wall, zone_delta,
  // first_observation, went_backwards, jumped, zone_shifted, gave_up, anomaly,
  // same_boot_seen, zero fill
  output logic [303:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);
  import etr_pkg::*;

  logic [31:0] credit_max_q, ntp_slack_q;
  logic [16:0] care_tick_q;
  logic [11:0] tz_shift_q, tz_lowest_q;
  logic [10:0] tz_highest_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_max_q <= 32'd2592000; care_tick_q <= 17'd900; ntp_slack_q <= 32'd300;
      tz_shift_q <= 12'd60; tz_lowest_q <= 12'hD30; tz_highest_q <= 11'd840;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCreditMax: credit_max_q <= cfg_data_i;
        RegCareTick:  care_tick_q  <= cfg_data_i[16:0];
        RegNtpSlack:  ntp_slack_q  <= cfg_data_i;
        RegTzShift:   tz_shift_q   <= cfg_data_i[11:0];
        RegTzLowest:  tz_lowest_q  <= cfg_data_i[11:0];
        RegTzHighest: tz_highest_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  cmd_t    cmd;
  status_t status;
  logic    busy, out_load;
  logic [303:0] result;
  logic    in_fire;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  etr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_free_i(!m_axis_tvalid || m_axis_tready),
    .status_i(status), .cmd_o(cmd), .busy_o(busy), .out_load_o(out_load));

  etr_dp #(.TagBytes(TagBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .in_data_i(s_axis_tdata),
    .credit_max_i(credit_max_q), .care_tick_i(care_tick_q), .ntp_slack_i(ntp_slack_q),
    .tz_shift_i(tz_shift_q), .tz_lowest_i(tz_lowest_q), .tz_highest_i(tz_highest_q),
    .result_o(result));

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (out_load) m_axis_tdata <= result;
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_axis_tvalid || m_axis_tready)) else $error("result overwritten");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !s_axis_tready) else $error("accepted while dividing");
  a_start_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.compare) else $error("sequence broken");

endmodule
`default_nettype wire

// ===== bench/tb_elapsed_time_reconciler_unit.sv =====
// Testbench for the elapsed-time reconciler: directed and random observations, scoreboarded.
`default_nettype none
module tb_elapsed_time_reconciler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import etr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 50;
  localparam logic [63:0] MaxS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinS = 64'h8000_0000_0000_0000;
  // indexes with no register behind them
  localparam logic [2:0] RegUnusedA = 3'd6;
  localparam logic [2:0] RegUnusedB = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [303:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  elapsed_time_reconciler_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // observations waiting to be sent, results still owed
  logic [287:0] obs_q[$];
  logic [303:0] owed_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;

  // shadow registers and anchor state
  logic [31:0] cap_secs;
  logic [16:0] tick_secs;
  logic [31:0] slack_secs;
  logic [11:0] shift_mins;
  longint lowest_mins;
  longint highest_mins;
  longint anc_wall, anc_boot, anc_zone;
  logic [127:0] anc_tag;
  logic anc_valid;
  logic [63:0] carry_secs;
  logic [63:0] care_sum;

  function automatic logic [63:0] clamp_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? MinS : MaxS;
    return d[63:0];
  endfunction

  function automatic longint abs_clamped(input longint v);
    if (v >= 0) return v;
    if (v == longint'(MinS)) return longint'(MaxS);
    return -v;
  endfunction

  // expected result of one observation; advances the anchor
  function automatic logic [303:0] reconcile(input logic [287:0] d);
    longint now_wall, now_boot, now_zone, wall_gap, boot_gap, t, zdelta, nxt;
    logic [63:0] tick, trusted, credited, pending, ticks, remaining;
    logic first, back, jump, shifted, gave, same;
    logic [303:0] r;
    now_wall = longint'(d[63:0]);
    now_boot = longint'(d[127:64]);
    now_zone = longint'(int'(d[287:256]));
    if (now_zone < lowest_mins || now_zone > highest_mins) now_zone = 0;
    tick = (tick_secs == 0) ? 64'd1 : 64'(tick_secs);
    trusted = 0; credited = 0; zdelta = 0;
    first = 0; back = 0; jump = 0; shifted = 0; gave = 0; same = 0;
    if (!anc_valid) begin
      first = 1;
    end else begin
      zdelta = now_zone - anc_zone;
      shifted = abs_clamped(zdelta) >= longint'(shift_mins);
      wall_gap = longint'(clamp_sub(now_wall, anc_wall));
      boot_gap = longint'(clamp_sub(now_boot, anc_boot));
      same = (d[255:128] == anc_tag);
      back = wall_gap < 0;
      if (same && boot_gap >= 0) begin
        if (wall_gap < 0) begin
          t = boot_gap;
        end else begin
          t = (wall_gap < boot_gap) ? wall_gap : boot_gap;
          if (!shifted)
            jump = abs_clamped(longint'(clamp_sub(wall_gap, boot_gap))) > longint'(slack_secs);
        end
      end else begin
        t = wall_gap;
      end
      if (t < 0) t = 0;
      trusted = t;
      credited = (trusted < 64'(cap_secs)) ? trusted : 64'(cap_secs);
      gave = trusted > 64'(cap_secs);
    end
    pending = carry_secs + credited;
    ticks = pending / tick;
    if (ticks > 64'hFFFF_FFFF) ticks = 64'hFFFF_FFFF;
    carry_secs = pending % tick;
    care_sum += credited;
    anc_wall = now_wall; anc_boot = now_boot; anc_tag = d[255:128];
    anc_zone = now_zone; anc_valid = 1;
    remaining = tick - carry_secs;
    if (now_wall > longint'(MaxS) - longint'(remaining)) nxt = longint'(MaxS);
    else nxt = now_wall + longint'(remaining);
    r = '0;
    r[62:0] = trusted[62:0];
    r[94:63] = credited[31:0];
    r[126:95] = ticks[31:0];
    r[190:127] = nxt;
    r[203:191] = zdelta[12:0];
    r[210:204] = {same, back | jump, gave, shifted, jump, back, first};
    return r;
  endfunction

  // sender: accepted request is predicted, next one popped
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) owed_q.push_back(reconcile(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (obs_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= obs_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each result with the oldest owed one
  always @(posedge clk_i) begin
    logic [303:0] e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          failures++;
        end else begin
          e = owed_q.pop_front();
          if (e[62:0] != m_axis_tdata[62:0]) begin
            $error("trusted_seconds exp %0d got %0d", e[62:0], m_axis_tdata[62:0]); failures++;
          end
          if (e[94:63] != m_axis_tdata[94:63]) begin
            $error("credited_seconds exp %0d got %0d", e[94:63], m_axis_tdata[94:63]);
            failures++;
          end
          if (e[126:95] != m_axis_tdata[126:95]) begin
            $error("ticks_earned exp %0d got %0d", e[126:95], m_axis_tdata[126:95]); failures++;
          end
          if (e[190:127] != m_axis_tdata[190:127]) begin
            $error("next_tick_wall exp %0d got %0d", $signed(e[190:127]),
                   $signed(m_axis_tdata[190:127])); failures++;
          end
          if (e[203:191] != m_axis_tdata[203:191]) begin
            $error("zone_delta exp %0d got %0d", $signed(e[203:191]),
                   $signed(m_axis_tdata[203:191])); failures++;
          end
          if (e[204] != m_axis_tdata[204]) begin
            $error("first_observation exp %0b got %0b", e[204], m_axis_tdata[204]); failures++;
          end
          if (e[205] != m_axis_tdata[205]) begin
            $error("went_backwards exp %0b got %0b", e[205], m_axis_tdata[205]); failures++;
          end
          if (e[206] != m_axis_tdata[206]) begin
            $error("jumped exp %0b got %0b", e[206], m_axis_tdata[206]); failures++;
          end
          if (e[207] != m_axis_tdata[207]) begin
            $error("zone_shifted exp %0b got %0b", e[207], m_axis_tdata[207]); failures++;
          end
          if (e[208] != m_axis_tdata[208]) begin
            $error("gave_up exp %0b got %0b", e[208], m_axis_tdata[208]); failures++;
          end
          if (e[209] != m_axis_tdata[209]) begin
            $error("anomaly exp %0b got %0b", e[209], m_axis_tdata[209]); failures++;
          end
          if (e[210] != m_axis_tdata[210]) begin
            $error("same_boot_seen exp %0b got %0b", e[210], m_axis_tdata[210]); failures++;
          end
          if (m_axis_tdata[303:211] != '0) begin
            $error("zero fill exp 0 got %h", m_axis_tdata[303:211]); failures++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegCreditMax: cap_secs = val;
      RegCareTick:  tick_secs = val[16:0];
      RegNtpSlack:  slack_secs = val;
      RegTzShift:   shift_mins = val[11:0];
      RegTzLowest:  lowest_mins = longint'($signed(val[11:0]));
      RegTzHighest: highest_mins = longint'(val[10:0]);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (obs_q.size() > 0 || s_axis_tvalid || owed_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_obs(input logic [63:0] w, input logic [63:0] b, input logic [127:0] tag,
                         input logic [31:0] z);
    obs_q.push_back({z, tag, b, w});
  endtask

  // mostly plausible clock histories with random content, some noise
  task automatic add_history(input int unsigned n);
    logic [63:0] w, b;
    logic [127:0] tag;
    logic [31:0] z;
    int unsigned k;
    w = {$urandom, $urandom} >> 2;
    b = $urandom;
    tag = {$urandom, $urandom, $urandom, $urandom};
    z = $urandom_range(2880) - 1440;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 12) begin
        add_obs({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom, $urandom, $urandom}, $urandom);
      end else begin
        if (k < 20) begin
          tag = {$urandom, $urandom, $urandom, $urandom};
          b = $urandom_range(1000);
          w += $urandom_range(200000);
        end else if (k < 26) begin
          w -= $urandom_range(100000);
          b += $urandom_range(3000);
        end else if (k < 30) begin
          b -= $urandom_range(3000);
          w += $urandom_range(3000);
        end else if (k < 36) begin
          w += {$urandom_range(7), $urandom};
          b += $urandom_range(5000);
        end else begin
          b += $urandom_range(5000);
          w = b - (b - w) + $urandom_range(5000);
          if ($urandom_range(3) == 0) w += $urandom_range(1000);
        end
        if ($urandom_range(5) == 0) z = $urandom_range(2880) - 1440;
        if ($urandom_range(20) == 0) z = $urandom;
        add_obs(w, b, tag, z);
      end
    end
  endtask

  typedef struct {
    logic [31:0] cap, tick, slack, shift, low, high;
    int unsigned idle, stall;
  } phase_t;

  initial begin
    phase_t ph[4];
    logic [127:0] t0;
    cap_secs = 32'd2592000; tick_secs = 17'd900; slack_secs = 32'd300; shift_mins = 12'd60;
    lowest_mins = -720; highest_mins = 840;
    anc_wall = 0; anc_boot = 0; anc_zone = 0; anc_tag = '0; anc_valid = 0;
    carry_secs = 0; care_sum = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults first, then edge cases
    t0 = 128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210;
    add_obs(64'd1000, 64'd10, t0, 32'd60);
    add_obs(64'd1500, 64'd510, t0, 32'd60);
    add_obs(64'd1400, 64'd600, t0, 32'd60);
    add_obs(64'd5000, 64'd700, t0, 32'd60);
    add_obs(64'd9000, 64'd800, t0, 32'd200);
    add_obs(64'd9500, 64'd100, t0, 32'd200);
    add_obs(64'd20000, 64'd5, ~t0, -32'd720);
    add_obs(64'd20000 + 64'd5000000, 64'd10, ~t0, -32'd721);
    add_obs(MaxS, 64'd20, ~t0, 32'd841);
    add_obs(MinS, MaxS, ~t0, 32'h8000_0000);
    add_obs(MaxS, MinS, ~t0, 32'h7FFF_FFFF);
    add_obs(MaxS - 64'd3, MinS, ~t0, 32'd840);
    add_obs(64'd0, 64'd0, '0, 32'd0);
    add_obs(64'd300, 64'd0, '0, 32'd0);
    add_obs(64'd901, 64'd1, '0, 32'd0);
    drain();

    write_reg(RegUnusedA, 32'hFFFF_FFFF);
    write_reg(RegUnusedB, 32'd1);
    ph[0] = '{32'd1, 32'd0, 32'd0, 32'd0, 32'hFFFF_FA60, 32'd1440, 0, 0};
    ph[1] = '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd2880, 32'd0, 32'd0, 49, 0};
    ph[2] = '{32'd100000, 32'd86400, 32'd1000, 32'd30, 32'hFFFF_FD00, 32'd600, 0, 49};
    ph[3] = '{32'd2592000, 32'd900, 32'd300, 32'd60, 32'hFFFF_FD30, 32'd840, 34, 34};
    foreach (ph[i]) begin
      write_reg(RegCreditMax, ph[i].cap);
      write_reg(RegCareTick, ph[i].tick);
      write_reg(RegNtpSlack, ph[i].slack);
      write_reg(RegTzShift, ph[i].shift);
      write_reg(RegTzLowest, ph[i].low);
      write_reg(RegTzHighest, ph[i].high);
      send_idle_pct = ph[i].idle;
      recv_stall_pct = ph[i].stall;
      add_history(50);
      // the next batch waits until every result is back
      while (obs_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
      while (owed_q.size() > 0) @(posedge clk_i);
      add_history(50);
      drain();
      // a large wall gap on the same boot with tick length one: the boot gap is trusted and a jump is flagged
      if (i == 1) begin
        add_obs(64'd0, 64'd0, t0, 32'd0);
        add_obs(MaxS, 64'd1, t0, 32'd0);
        drain();
      end
    end

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
